FILE: sv/dsrm_pkg.sv
// Package for the dot-star pattern matcher.
// Holds the configuration register indexes, the register bundle, and the item and result types.
// No dependencies; every other file imports it.
package dsrm_pkg;

  // Largest pattern the block is built for.
  localparam int MAX_TOKENS = 16;

  // Widths fixed by the register and field definitions.
  localparam int CharsW = 64;
  localparam int MaskW  = 16;
  localparam int CountW = 5;
  localparam int IndexW = 3;
  localparam int CfgW   = 64;

  typedef enum logic [IndexW-1:0] {
    CfgCharsLow  = 3'd0,
    CfgCharsHigh = 3'd1,
    CfgWildcard  = 3'd2,
    CfgRepeat    = 3'd3,
    CfgCount     = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [2*CharsW-1:0] token_chars;   // token t in bits 8t+7..8t
    logic [MaskW-1:0]    wildcard_mask;
    logic [MaskW-1:0]    repeat_mask;
    logic [CountW-1:0]   token_count;
  } cfg_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       has_byte;
    logic       last_of_text;
  } item_t;

  typedef struct packed {
    logic whole_match;
    logic still_alive;
    logic text_done;
  } result_t;

endpackage

FILE: sv/dsrm_cfg_regs.sv
// Configuration register file of the dot-star pattern matcher.
// Takes register writes by index and presents them as one bundle.
// Depends on dsrm_pkg.
module dsrm_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic [dsrm_pkg::IndexW-1:0]   cfg_index_i,
  input  logic [dsrm_pkg::CfgW-1:0]     cfg_data_i,
  output dsrm_pkg::cfg_t                cfg_o
);
  import dsrm_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CfgCharsLow:  cfg_q.token_chars[CharsW-1:0]        <= cfg_data_i[CharsW-1:0];
        CfgCharsHigh: cfg_q.token_chars[2*CharsW-1:CharsW] <= cfg_data_i[CharsW-1:0];
        CfgWildcard:  cfg_q.wildcard_mask                  <= cfg_data_i[MaskW-1:0];
        CfgRepeat:    cfg_q.repeat_mask                    <= cfg_data_i[MaskW-1:0];
        CfgCount:     cfg_q.token_count                    <= cfg_data_i[CountW-1:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: sv/dsrm_step.sv
// Next-state logic of the dot-star pattern matcher for one text item.
// Closure on starred tokens; a byte adds per-token compare, advance, closure.
// Depends on dsrm_pkg.
module dsrm_step #(
  parameter int MaxTokens = dsrm_pkg::MAX_TOKENS
) (
  input  dsrm_pkg::cfg_t    cfg_i,
  input  logic [MaxTokens:0] state_i,
  input  dsrm_pkg::item_t   item_i,
  output logic [MaxTokens:0] state_o,
  output dsrm_pkg::result_t result_o
);
  import dsrm_pkg::*;

  localparam int Positions = MaxTokens + 1;
  localparam int Levels    = $clog2(Positions);
  localparam logic [CountW-1:0] CountMax = CountW'(MaxTokens);

  logic [CountW-1:0]    n;
  logic [Positions-1:0] live;
  logic [Positions-1:0] at_n;
  logic [MaxTokens-1:0] in_use;
  logic [MaxTokens-1:0] rep_eff;
  logic [MaxTokens-1:0] hit;
  logic [Positions-1:0] cur_start;
  logic [Positions-1:0] next_raw;
  logic [Positions-1:0] cur_byte;
  logic [Positions-1:0] cur;

  // Closure: a position spreads forward across a run of starred tokens.
  // Parallel prefix form, one doubling step per level.
  function automatic logic [Positions-1:0] close_set(input logic [Positions-1:0] s,
                                                     input logic [MaxTokens-1:0] r);
    logic [Positions-1:0] g;
    logic [Positions-1:0] pr;
    g  = s;
    pr = {r, 1'b0};
    for (int lvl = 0; lvl < Levels; lvl++) begin
      g  = g | (pr & (g << (1 << lvl)));
      pr = pr & (pr << (1 << lvl));
    end
    return g;
  endfunction

  assign n = (cfg_i.token_count > CountMax) ? CountMax : cfg_i.token_count;

  for (genvar i = 0; i < Positions; i++) begin : g_pos
    assign live[i] = (CountW'(i) <= n);
    assign at_n[i] = (CountW'(i) == n);
  end

  for (genvar p = 0; p < MaxTokens; p++) begin : g_tok
    assign in_use[p]  = (CountW'(p) < n);
    assign rep_eff[p] = cfg_i.repeat_mask[p] & in_use[p];
    assign hit[p]     = cur_start[p] & in_use[p] &
                        (cfg_i.wildcard_mask[p] |
                         (cfg_i.token_chars[8*p +: 8] == item_i.text_byte));
  end

  assign cur_start = close_set(state_i & live, rep_eff);

  // A starred token holds its position on a hit; a plain token moves one on.
  assign next_raw = {1'b0, hit & rep_eff} | {hit & ~rep_eff, 1'b0};
  assign cur_byte = close_set(next_raw & live, rep_eff);
  assign cur      = item_i.has_byte ? cur_byte : cur_start;

  assign result_o.whole_match = |(cur & at_n);
  assign result_o.still_alive = |cur;
  assign result_o.text_done   = item_i.last_of_text;

  assign state_o = item_i.last_of_text ? Positions'(1) : cur;

endmodule

FILE: sv/dot_star_regex_matcher.sv
// Top level of the dot-star pattern matcher.
// Input register, next-state step, result register and active-position register.
// Depends on dsrm_pkg, dsrm_cfg_regs and dsrm_step.
//
//   Channel   Direction  Handshake                    Payload
//   s_axis    in         s_axis_tvalid/s_axis_tready  tdata: text_byte; tuser: has_byte;
//                                                     tlast: last_of_text
//   m_axis    out        m_axis_tvalid/m_axis_tready  tdata: whole_match, still_alive;
//                                                     tlast: text_done
//   cfg       in         cfg_valid_i/cfg_ready_o      cfg_index_i, cfg_data_i
//
// Every item, with or without a text byte, gives exactly one result: it is held in the
// input register, then the step logic writes the output register.
// The active positions update as an item moves on, so with m_axis_tready high one item
// is taken every cycle. A stall on m_axis holds both registers and drops s_axis_tready
// once the input register is full. Reset clears both valid flags and the configuration
// and leaves only the start position active.
module dot_star_regex_matcher #(
  parameter int MaxTokens = dsrm_pkg::MAX_TOKENS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Input stream.
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [7:0]                  s_axis_tdata,   // [7:0] text_byte
  input  logic                        s_axis_tuser,   // [0] has_byte
  input  logic                        s_axis_tlast,   // last_of_text
  // Result stream.
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [7:0]                  m_axis_tdata,   // [0] whole_match, [1] still_alive
  output logic                        m_axis_tlast,   // text_done
  // Configuration writes.
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [dsrm_pkg::IndexW-1:0] cfg_index_i,
  input  logic [dsrm_pkg::CfgW-1:0]   cfg_data_i
);
  import dsrm_pkg::*;

  localparam int Positions = MaxTokens + 1;

  cfg_t                 cfg;
  logic                 in_valid_q;
  item_t                in_item_q;
  logic                 out_valid_q;
  result_t              out_res_q;
  logic [Positions-1:0] state_q;
  logic [Positions-1:0] state_d;
  result_t              step_res;
  logic                 out_free;
  logic                 advance;
  logic                 in_take;

  // Registers are always writable.
  assign cfg_ready_o = 1'b1;

  dsrm_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  dsrm_step #(
    .MaxTokens (MaxTokens)
  ) u_step (
    .cfg_i    (cfg),
    .state_i  (state_q),
    .item_i   (in_item_q),
    .state_o  (state_d),
    .result_o (step_res)
  );

  // The output register frees up when empty or when its result is taken this cycle.
  assign out_free      = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= Positions'(1);
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        state_q     <= state_d;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_item_q.text_byte    <= s_axis_tdata;
      in_item_q.has_byte     <= s_axis_tuser;
      in_item_q.last_of_text <= s_axis_tlast;
    end
    if (advance) begin
      out_res_q <= step_res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b0, out_res_q.still_alive, out_res_q.whole_match};
  assign m_axis_tlast  = out_res_q.text_done;

endmodule

FILE: tb/sv/dot_star_regex_matcher_tb.sv
// Self-checking testbench for the dot-star pattern matcher.
// Drives text streams and register writes, predicts every verdict and checks each result.
// Depends on dsrm_pkg and the dot_star_regex_matcher top level.
module dot_star_regex_matcher_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dsrm_pkg::*;

  // Upper bound on the whole run, in clock cycles.
  localparam int RunLimit = 500000;

  logic     clk_i  = 1'b0;
  logic     rst_ni = 1'b0;

  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata  = '0;   // [7:0] text_byte
  logic       s_axis_tuser  = 1'b0; // [0] has_byte
  logic       s_axis_tlast  = 1'b0; // last_of_text

  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;         // [0] whole_match, [1] still_alive, [7:2] zero
  logic       m_axis_tlast;         // text_done

  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  cfg_reg_e    cfg_index   = CfgCharsLow;
  logic [63:0] cfg_data_i  = '0;

  dot_star_regex_matcher uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data_i)
  );

  // Idle rates in percent for the two stream sides, and a stretch of forced
  // receiver stall that the checker process counts down cycle by cycle.
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned stall_left    = 0;

  int unsigned error_count = 0;
  int unsigned cycle_count = 0;

  // Verdicts predicted for accepted text items, oldest first.
  result_t verdict_q[$];

  // Shadow of the pattern registers and of the active-position set.
  logic [127:0] pat_chars  = '0;
  logic [15:0]  pat_wild   = '0;
  logic [15:0]  pat_repeat = '0;
  logic [4:0]   pat_count  = '0;
  logic [16:0]  active_pos = 17'd1;

  // 4 ns clock.
  initial begin
    forever #2ns clk_i = ~clk_i;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    while (cycle_count < RunLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("TB_ERROR");
    $finish;
  end

  function automatic int pattern_len();
    return (pat_count > MAX_TOKENS) ? MAX_TOKENS : int'(pat_count);
  endfunction

  // Epsilon closure: drop positions past the accepting one, then let every
  // active starred token also activate the position after it.
  function automatic logic [16:0] close_positions(logic [16:0] pos, int len);
    int p;
    for (p = len + 1; p < 17; p++) pos[p] = 1'b0;
    for (p = 0; p < len; p++) begin
      if (pos[p] && pat_repeat[p]) pos[p+1] = 1'b1;
    end
    return pos;
  endfunction

  // Advances the shadow automaton by one item and returns the verdict it gives.
  function automatic result_t match_step(item_t it);
    logic [16:0] cur;
    logic [16:0] nxt;
    int          len;
    int          p;
    result_t     r;
    len = pattern_len();
    cur = close_positions(active_pos, len);
    if (it.has_byte) begin
      nxt = '0;
      for (p = 0; p < len; p++) begin
        if (cur[p] && (pat_wild[p] || pat_chars[8*p +: 8] == it.text_byte)) begin
          // A starred token stays put after a hit; a plain one moves on.
          if (pat_repeat[p]) nxt[p] = 1'b1;
          else nxt[p+1] = 1'b1;
        end
      end
      cur = close_positions(nxt, len);
    end
    r.whole_match  = cur[len];
    r.still_alive  = |cur;
    r.text_done    = it.last_of_text;
    active_pos     = it.last_of_text ? 17'd1 : cur;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [7:0] exp_v, logic [7:0] got_v);
    $display("mismatch on %s: expected %0h, got %0h (cycle %0d)", what, exp_v, got_v,
             cycle_count);
    error_count++;
  endtask

  // Result side: checks every transfer on m_axis and decides tready for the next
  // cycle. Sampling right at the edge sees the values from before the edge.
  initial begin
    result_t exp_r;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        if (verdict_q.size() == 0) begin
          report_mismatch("unexpected result", 8'h00, m_axis_tdata);
        end else begin
          exp_r = verdict_q.pop_front();
          if (m_axis_tdata[0] !== exp_r.whole_match)
            report_mismatch("whole_match", exp_r.whole_match, m_axis_tdata[0]);
          if (m_axis_tdata[1] !== exp_r.still_alive)
            report_mismatch("still_alive", exp_r.still_alive, m_axis_tdata[1]);
          if (m_axis_tlast !== exp_r.text_done)
            report_mismatch("text_done", exp_r.text_done, m_axis_tlast);
          if (m_axis_tdata[7:2] !== 6'd0)
            report_mismatch("tdata padding", 8'h00, m_axis_tdata);
        end
      end
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Offers one item and returns at the edge where it is taken. tvalid is left
  // high so that back-to-back items keep it asserted; wait_idle lowers it.
  task automatic send_item(item_t it);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= it.text_byte;
    s_axis_tuser  <= it.has_byte;
    s_axis_tlast  <= it.last_of_text;
    do @(posedge clk_i); while (!s_axis_tready);
    verdict_q.push_back(match_step(it));
  endtask

  function automatic item_t make_item(logic [7:0] b, logic has, logic last);
    item_t it;
    it.text_byte    = b;
    it.has_byte     = has;
    it.last_of_text = last;
    return it;
  endfunction

  // Stops offering and waits until every verdict is back.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // One register transfer. cfg_valid_i stays high so several writes can follow
  // each other; the caller lowers it when done.
  task automatic write_reg(cfg_reg_e idx, logic [63:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index   <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CfgCharsLow:  pat_chars[63:0]   = data;
      CfgCharsHigh: pat_chars[127:64] = data;
      CfgWildcard:  pat_wild          = data[15:0];
      CfgRepeat:    pat_repeat        = data[15:0];
      CfgCount:     pat_count         = data[4:0];
      default: ;
    endcase
  endtask

  task automatic load_pattern(logic [127:0] chars, logic [15:0] wild, logic [15:0] rep,
                              logic [4:0] count);
    wait_idle();
    write_reg(CfgCharsLow, chars[63:0]);
    write_reg(CfgCharsHigh, chars[127:64]);
    write_reg(CfgWildcard, {48'd0, wild});
    write_reg(CfgRepeat, {48'd0, rep});
    write_reg(CfgCount, {59'd0, count});
    cfg_valid_i <= 1'b0;
  endtask

  // Mostly letters from a three-letter alphabet so random text actually matches.
  function automatic logic [7:0] pick_char();
    if ($urandom_range(9) < 7) return 8'h61 + 8'($urandom_range(2));
    return 8'($urandom_range(255));
  endfunction

  task automatic load_random_pattern();
    logic [127:0] chars;
    logic [15:0]  wild;
    logic [15:0]  rep;
    logic [4:0]   count;
    int           sel;
    for (int t = 0; t < 16; t++) begin
      chars[8*t +: 8] = pick_char();
      wild[t]         = ($urandom_range(3) == 0);
      rep[t]          = ($urandom_range(99) < 35);
    end
    sel = $urandom_range(99);
    if (sel < 8) count = 5'd0;
    else if (sel < 18) count = 5'd16;
    else if (sel < 24) count = 5'($urandom_range(17, 31));
    else count = 5'($urandom_range(1, 8));
    load_pattern(chars, wild, rep, count);
  endtask

  // Builds one text and sends it. Most texts follow the pattern token by token
  // with random repeat counts and the odd corrupted byte; the rest are free text,
  // empty texts and noise with byte-less items mixed in.
  task automatic send_random_text(output int sent);
    item_t txt[$];
    int    mode;
    int    reps;
    int    len;
    logic [7:0] b;
    len  = pattern_len();
    mode = $urandom_range(99);
    if (mode < 60) begin
      for (int t = 0; t < len; t++) begin
        reps = pat_repeat[t] ? $urandom_range(0, 3) : 1;
        repeat (reps) begin
          b = pat_wild[t] ? 8'($urandom_range(255)) : pat_chars[8*t +: 8];
          if ($urandom_range(99) < 6) b = pick_char();
          txt.push_back(make_item(b, 1'b1, 1'b0));
          if ($urandom_range(99) < 5)
            txt.push_back(make_item(8'($urandom_range(255)), 1'b0, 1'b0));
        end
      end
      if ($urandom_range(99) < 15) txt.push_back(make_item(pick_char(), 1'b1, 1'b0));
    end else if (mode < 75) begin
      repeat ($urandom_range(0, 8)) txt.push_back(make_item(pick_char(), 1'b1, 1'b0));
    end else if (mode < 85) begin
      // Empty text: only the closing item below.
    end else begin
      repeat ($urandom_range(1, 6))
        txt.push_back(make_item(8'($urandom_range(255)), ($urandom_range(3) != 0), 1'b0));
    end
    if (txt.size() == 0 || $urandom_range(9) == 0)
      txt.push_back(make_item(8'($urandom_range(255)), 1'b0, 1'b0));
    txt[txt.size()-1].last_of_text = 1'b1;
    foreach (txt[i]) send_item(txt[i]);
    sent = txt.size();
  endtask

  // Out of reset the pattern is empty: empty text matches, any byte kills it.
  task automatic test_reset_state();
    send_item(make_item(8'h00, 1'b0, 1'b1));
    send_item(make_item(8'h00, 1'b1, 1'b1));
    send_item(make_item(8'hFF, 1'b1, 1'b1));
  endtask

  // Sixteen tokens with extreme literals at both ends and starred fillers between,
  // so both character registers are in play.
  task automatic test_literal_extremes();
    load_pattern({8'h00, {14{8'h5A}}, 8'hFF}, 16'h0000, 16'h7FFE, 5'd16);
    send_item(make_item(8'hFF, 1'b1, 1'b0));
    send_item(make_item(8'h00, 1'b1, 1'b1));
    send_item(make_item(8'hFF, 1'b1, 1'b0));
    send_item(make_item(8'h5A, 1'b1, 1'b0));
    send_item(make_item(8'h5A, 1'b1, 1'b0));
    send_item(make_item(8'h00, 1'b1, 1'b1));
    send_item(make_item(8'h00, 1'b1, 1'b1));
  endtask

  // All tokens dot-star: empty text and any bytes match. A count above the
  // maximum is clamped to sixteen tokens.
  task automatic test_all_dot_star();
    load_pattern({128{1'b1}}, 16'hFFFF, 16'hFFFF, 5'd16);
    send_item(make_item(8'h00, 1'b0, 1'b1));
    send_item(make_item(8'hA5, 1'b1, 1'b0));
    send_item(make_item(8'h5A, 1'b1, 1'b1));
    load_pattern('0, 16'hFFFF, 16'hFFFF, 5'd31);
    send_item(make_item(8'h00, 1'b1, 1'b1));
    send_item(make_item(8'hFF, 1'b0, 1'b1));
  endtask

  // A dot ignores its literal byte. After a miss the text is dead for good, and a
  // byte-less item in the middle only reports the current verdict.
  task automatic test_dot_and_dead_text();
    load_pattern({120'd0, 8'h78}, 16'h0001, 16'h0000, 5'd1);
    send_item(make_item(8'h79, 1'b1, 1'b1));
    send_item(make_item(8'h7A, 1'b1, 1'b0));
    send_item(make_item(8'h7A, 1'b0, 1'b0));
    send_item(make_item(8'h7A, 1'b1, 1'b1));
  endtask

  // Token count rewritten in the middle of a text: positions past the new
  // accepting position disappear.
  task automatic test_count_change_mid_text();
    load_pattern({112'd0, 8'h62, 8'h61}, 16'h0000, 16'h0000, 5'd2);
    send_item(make_item(8'h61, 1'b1, 1'b0));
    wait_idle();
    write_reg(CfgCount, 64'd1);
    cfg_valid_i <= 1'b0;
    send_item(make_item(8'h00, 1'b0, 1'b1));
    wait_idle();
    write_reg(CfgCount, 64'd2);
    cfg_valid_i <= 1'b0;
    send_item(make_item(8'h61, 1'b1, 1'b0));
    wait_idle();
    write_reg(CfgCount, 64'd0);
    cfg_valid_i <= 1'b0;
    send_item(make_item(8'h62, 1'b1, 1'b1));
  endtask

  // The receiver holds off for a long stretch while items keep coming, so the
  // block fills up and drops s_axis_tready.
  task automatic test_output_stall();
    int sent;
    int total;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    load_random_pattern();
    stall_left = 300;
    total = 0;
    while (total < 40) begin
      send_random_text(sent);
      total += sent;
    end
  endtask

  task automatic test_random_traffic(int items, int unsigned src_pct, int unsigned dst_pct);
    int sent;
    int total;
    send_idle_pct = src_pct;
    recv_idle_pct = dst_pct;
    total = 0;
    while (total < items) begin
      load_random_pattern();
      repeat ($urandom_range(3, 10)) begin
        send_random_text(sent);
        total += sent;
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_literal_extremes();
    test_all_dot_star();
    test_dot_and_dead_text();
    test_count_change_mid_text();
    test_output_stall();
    test_random_traffic(400, 14, 57);
    test_random_traffic(400, 57, 14);
    test_random_traffic(400, 0, 0);

    wait_idle();
    repeat (8) @(posedge clk_i);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: dot_star_regex_matcher.f
sv/dsrm_pkg.sv
sv/dsrm_cfg_regs.sv
sv/dsrm_step.sv
sv/dot_star_regex_matcher.sv
tb/sv/dot_star_regex_matcher_tb.sv
